/* rtl/triangle_cull_and_project_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the triangle cull and project unit
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CULL_AND_PROJECT_UNIT_ASSERT_SVH
`define TRIANGLE_CULL_AND_PROJECT_UNIT_ASSERT_SVH

// same-cycle implication
`define TCP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tcp assertion failed");

// next-cycle implication
`define TCP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tcp assertion failed");

`endif

/* rtl/tcp_pkg.sv */
// ----------------------------------------------------------------------------
// tcp_pkg
// Types, widths and helpers shared by the cull and project pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CRD_W     = 32;
   localparam int T_W       = 33;   // translated / difference coordinate
   localparam int W_W       = 34;   // w after zero substitution
   localparam int SUM_W     = 67;   // projected coordinate plus w scaled
   localparam int NUM_W     = 81;   // numerator after viewport scale
   localparam int DW_W      = 33;   // |w|
   localparam int Q_W       = 17;   // quotient bits before saturation
   localparam int RW        = 34;   // divider remainder
   localparam int MP_W      = NUM_W - FRAC_BITS;
   localparam int IMG_W     = 13;
   localparam int PIX_W     = 16;
   localparam int LO_SPLIT  = 34;

   localparam int CULL_LAT  = 7;
   localparam int PROJ_LAT  = 5;
   localparam int DIV_LAT   = Q_W + 4;
   localparam int TOTAL_LAT = PROJ_LAT + DIV_LAT;
   localparam int VIS_DLY   = TOTAL_LAT - CULL_LAT;

   typedef enum logic [2:0] {
      REG_CAM_X,
      REG_CAM_Y,
      REG_CAM_Z,
      REG_SCALE_X,
      REG_SKEW_X,
      REG_SCALE_Y,
      REG_IMG_W,
      REG_IMG_H
   } tcp_reg_type;

   typedef struct packed {
      logic signed [CRD_W-1:0] cam_x;
      logic signed [CRD_W-1:0] cam_y;
      logic signed [CRD_W-1:0] cam_z;
      logic signed [CRD_W-1:0] scale_x;
      logic signed [CRD_W-1:0] skew_x;
      logic signed [CRD_W-1:0] scale_y;
      logic [IMG_W-1:0]        img_w;
      logic [IMG_W-1:0]        img_h;
   } tcp_cfg_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] num;
      logic [DW_W-1:0]         dw;
      logic                    wneg;
   } tcp_div_in_type;

   function automatic logic signed [T_W-1:0] sub_ext(input logic signed [CRD_W-1:0] a,
                                                    input logic signed [CRD_W-1:0] b);
      return {a[CRD_W-1], a} - {b[CRD_W-1], b};
   endfunction

endpackage

`default_nettype wire

/* rtl/tcp_cull.sv */
// ----------------------------------------------------------------------------
// tcp_cull
// Back-face test: sign of dot(cross(v0-v1, v0-v2), v0-cam), exact.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_cull (
   input  wire                          clock,
   input  wire                          en,
   input  wire signed [tcp_pkg::CRD_W-1:0] v [9],
   input  wire tcp_pkg::tcp_cfg_type    cfg,
   output logic                         vis
);
   import tcp_pkg::*;

   logic signed [T_W-1:0]  a_ff [3];
   logic signed [T_W-1:0]  b_ff [3];
   logic signed [T_W-1:0]  c1_ff [3];
   logic signed [T_W-1:0]  c2_ff [3];
   logic signed [T_W-1:0]  c3_ff [3];
   logic signed [65:0]     p_ff [6];
   logic signed [66:0]     cr_ff [3];
   logic signed [67:0]     lo_ff [3];
   logic signed [65:0]     hi_ff [3];
   logic signed [99:0]     dd_ff [3];
   logic signed [101:0]    s01_ff;
   logic signed [99:0]     d2_ff;
   logic signed [101:0]    dot_in;
   logic                   vis_ff;
   logic                   vis_in;

   always_comb begin
      dot_in = s01_ff + 102'(d2_ff);
      vis_in = dot_in[101] | (dot_in == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]  <= sub_ext(v[0], v[3]);
         a_ff[1]  <= sub_ext(v[1], v[4]);
         a_ff[2]  <= sub_ext(v[2], v[5]);
         b_ff[0]  <= sub_ext(v[0], v[6]);
         b_ff[1]  <= sub_ext(v[1], v[7]);
         b_ff[2]  <= sub_ext(v[2], v[8]);
         c1_ff[0] <= sub_ext(v[0], cfg.cam_x);
         c1_ff[1] <= sub_ext(v[1], cfg.cam_y);
         c1_ff[2] <= sub_ext(v[2], cfg.cam_z);
         // cross product terms
         p_ff[0] <= a_ff[1] * b_ff[2];
         p_ff[1] <= a_ff[2] * b_ff[1];
         p_ff[2] <= a_ff[2] * b_ff[0];
         p_ff[3] <= a_ff[0] * b_ff[2];
         p_ff[4] <= a_ff[0] * b_ff[1];
         p_ff[5] <= a_ff[1] * b_ff[0];
         c2_ff   <= c1_ff;
         for (int i = 0; i < 3; i++) begin
            cr_ff[i] <= 67'(p_ff[2*i]) - 67'(p_ff[2*i+1]);
         end
         c3_ff <= c2_ff;
         // 67 x 33 split into low and high partial products
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= $signed({1'b0, cr_ff[i][LO_SPLIT-1:0]}) * c3_ff[i];
            hi_ff[i] <= $signed(cr_ff[i][66:LO_SPLIT]) * c3_ff[i];
         end
         for (int i = 0; i < 3; i++) begin
            dd_ff[i] <= (100'(hi_ff[i]) <<< LO_SPLIT) + 100'(lo_ff[i]);
         end
         s01_ff <= 102'(dd_ff[0]) + 102'(dd_ff[1]);
         d2_ff  <= dd_ff[2];
         vis_ff <= vis_in;
      end
   end

   assign vis = vis_ff;

endmodule

`default_nettype wire

/* rtl/tcp_proj.sv */
// ----------------------------------------------------------------------------
// tcp_proj
// Translate one vertex, apply the projection rows and viewport scale.
// Produces numerator and |w| for the x and y dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_proj (
   input  wire                             clock,
   input  wire                             en,
   input  wire signed [tcp_pkg::CRD_W-1:0] vx,
   input  wire signed [tcp_pkg::CRD_W-1:0] vy,
   input  wire signed [tcp_pkg::CRD_W-1:0] vz,
   input  wire tcp_pkg::tcp_cfg_type       cfg,
   output tcp_pkg::tcp_div_in_type         dx,
   output tcp_pkg::tcp_div_in_type         dy
);
   import tcp_pkg::*;

   localparam int WSC_W = W_W + FRAC_BITS;
   localparam int HI_W  = SUM_W - LO_SPLIT + IMG_W + 1;
   localparam int LO_W  = LO_SPLIT + IMG_W + 2;

   logic signed [T_W-1:0]   tx_ff, ty_ff, tz_ff, tz_in;
   logic signed [W_W-1:0]   w1_ff, w2_ff, w3_ff, w4_ff, w_in;
   logic signed [64:0]      sx_ff, kx_ff, sy_ff;
   logic signed [WSC_W-1:0] wsc_ff;
   logic signed [SUM_W-1:0] xs_ff, ys_ff;
   logic signed [HI_W-1:0]  xhi_ff, yhi_ff;
   logic signed [LO_W-1:0]  xlo_ff, ylo_ff;
   tcp_div_in_type          dx_ff, dy_ff;
   logic signed [W_W-1:0]   wabs;

   always_comb begin
      tz_in = sub_ext(vz, cfg.cam_z);
      // w of zero maps as w = 1.0
      w_in  = (tz_in == '0) ? W_W'(1 << FRAC_BITS) : -W_W'(tz_in);
      wabs  = w4_ff[W_W-1] ? -w4_ff : w4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tx_ff  <= sub_ext(vx, cfg.cam_x);
         ty_ff  <= sub_ext(vy, cfg.cam_y);
         tz_ff  <= tz_in;
         w1_ff  <= w_in;

         sx_ff  <= cfg.scale_x * tx_ff;
         kx_ff  <= cfg.skew_x * tz_ff;
         sy_ff  <= cfg.scale_y * ty_ff;
         wsc_ff <= {w1_ff, FRAC_BITS'(0)};
         w2_ff  <= w1_ff;

         xs_ff  <= SUM_W'(sx_ff) + SUM_W'(kx_ff) + SUM_W'(wsc_ff);
         ys_ff  <= SUM_W'(wsc_ff) - SUM_W'(sy_ff);
         w3_ff  <= w2_ff;

         xhi_ff <= $signed(xs_ff[SUM_W-1:LO_SPLIT]) * $signed({1'b0, cfg.img_w});
         xlo_ff <= $signed({1'b0, xs_ff[LO_SPLIT-1:0]}) * $signed({1'b0, cfg.img_w});
         yhi_ff <= $signed(ys_ff[SUM_W-1:LO_SPLIT]) * $signed({1'b0, cfg.img_h});
         ylo_ff <= $signed({1'b0, ys_ff[LO_SPLIT-1:0]}) * $signed({1'b0, cfg.img_h});
         w4_ff  <= w3_ff;

         dx_ff.num  <= (NUM_W'(xhi_ff) <<< LO_SPLIT) + NUM_W'(xlo_ff);
         dy_ff.num  <= (NUM_W'(yhi_ff) <<< LO_SPLIT) + NUM_W'(ylo_ff);
         dx_ff.dw   <= DW_W'(wabs);
         dy_ff.dw   <= DW_W'(wabs);
         dx_ff.wneg <= w4_ff[W_W-1];
         dy_ff.wneg <= w4_ff[W_W-1];
      end
   end

   assign dx = dx_ff;
   assign dy = dy_ff;

endmodule

`default_nettype wire

/* rtl/tcp_div.sv */
// ----------------------------------------------------------------------------
// tcp_div
// Pipelined rounding divide num / (2 w 2^F), one quotient bit per stage,
// then saturation to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_div (
   input  wire                            clock,
   input  wire                            en,
   input  wire tcp_pkg::tcp_div_in_type   din,
   output logic signed [tcp_pkg::PIX_W-1:0] pix
);
   import tcp_pkg::*;

   logic [NUM_W-1:0]   n_ff;
   logic [DW_W-1:0]    dw1_ff, dw2_ff;
   logic               neg1_ff, neg2_ff;
   logic [MP_W-1:0]    mp_ff;
   logic [NUM_W:0]     m_in;

   logic [RW-1:0]      r_ff   [Q_W+1];
   logic [Q_W-1:0]     lo_ff  [Q_W+1];
   logic [Q_W-1:0]     q_ff   [Q_W+1];
   logic [DW_W-1:0]    dw_ff  [Q_W+1];
   logic               neg_ff [Q_W+1];
   logic               ovf_ff [Q_W+1];
   logic [PIX_W-1:0]   pix_ff;

   // rounding: add half the divisor, then drop the 2^(F+1) factor
   assign m_in = (NUM_W+1)'(n_ff) + ((NUM_W+1)'(dw1_ff) << FRAC_BITS);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= din.num[NUM_W-1] ? NUM_W'(-din.num) : NUM_W'(din.num);
         neg1_ff <= din.num[NUM_W-1] ^ din.wneg;
         dw1_ff  <= din.dw;

         mp_ff   <= MP_W'(m_in >> (FRAC_BITS + 1));
         neg2_ff <= neg1_ff;
         dw2_ff  <= dw1_ff;

         ovf_ff[0] <= mp_ff >= (MP_W'(dw2_ff) << Q_W);
         r_ff[0]   <= RW'(mp_ff >> Q_W);
         lo_ff[0]  <= mp_ff[Q_W-1:0];
         q_ff[0]   <= '0;
         dw_ff[0]  <= dw2_ff;
         neg_ff[0] <= neg2_ff;
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_step
      logic [RW-1:0] t;
      logic          take;
      always_comb begin
         t    = {r_ff[k][RW-2:0], lo_ff[k][Q_W-1-k]};
         take = t >= RW'(dw_ff[k]);
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]   <= take ? t - RW'(dw_ff[k]) : t;
            q_ff[k+1]   <= q_ff[k] | (Q_W'(take) << (Q_W-1-k));
            lo_ff[k+1]  <= lo_ff[k];
            dw_ff[k+1]  <= dw_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (neg_ff[Q_W]) begin
            if (ovf_ff[Q_W] || q_ff[Q_W] > Q_W'(32768)) pix_ff <= 16'h8000;
            else pix_ff <= PIX_W'(-q_ff[Q_W]);
         end else begin
            if (ovf_ff[Q_W] || q_ff[Q_W] > Q_W'(32767)) pix_ff <= 16'h7FFF;
            else pix_ff <= PIX_W'(q_ff[Q_W]);
         end
      end
   end

   assign pix = pix_ff;

endmodule

`default_nettype wire

/* rtl/triangle_cull_and_project_unit.sv */
// ----------------------------------------------------------------------------
// triangle_cull_and_project_unit
// Pipeline: 5 projection stages and 21 divider stages; each divider step
// stage (g_step) yields one quotient bit.
// Throughput: one triangle per cycle; the pipeline stalls as a whole only
// while a result waits on rsp_tready.
// Reset: synchronous; clears stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_cull_and_project_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
   input  wire [287:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // px0, py0, px1, py1, px2, py2
   output logic [95:0] rsp_tdata,
   // visible
   output logic        rsp_tuser,
   input  wire         csr_wen,
   input  wire [2:0]   csr_addr,
   input  wire [31:0]  csr_wdata
);
   import tcp_pkg::*;

   tcp_cfg_type           cfg_ff;
   logic [TOTAL_LAT-1:0]  valid_ff;
   logic                  adv;
   logic signed [CRD_W-1:0] v [9];
   logic                  vis_c;
   logic                  vis_dly_ff [VIS_DLY];
   tcp_div_in_type        dx [3];
   tcp_div_in_type        dy [3];
   logic signed [PIX_W-1:0] pxs [3];
   logic signed [PIX_W-1:0] pys [3];
   logic                  vis;

   assign adv        = !valid_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_x   <= '0;
         cfg_ff.cam_y   <= '0;
         cfg_ff.cam_z   <= '0;
         cfg_ff.scale_x <= 32'sd65536;
         cfg_ff.skew_x  <= '0;
         cfg_ff.scale_y <= 32'sd65536;
         cfg_ff.img_w   <= 13'd640;
         cfg_ff.img_h   <= 13'd480;
      end else if (csr_wen) begin
         case (tcp_reg_type'(csr_addr))
            REG_CAM_X:   cfg_ff.cam_x   <= csr_wdata;
            REG_CAM_Y:   cfg_ff.cam_y   <= csr_wdata;
            REG_CAM_Z:   cfg_ff.cam_z   <= csr_wdata;
            REG_SCALE_X: cfg_ff.scale_x <= csr_wdata;
            REG_SKEW_X:  cfg_ff.skew_x  <= csr_wdata;
            REG_SCALE_Y: cfg_ff.scale_y <= csr_wdata;
            REG_IMG_W:   cfg_ff.img_w   <= csr_wdata[IMG_W-1:0];
            REG_IMG_H:   cfg_ff.img_h   <= csr_wdata[IMG_W-1:0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < 9; i++) begin : g_unpack
      assign v[i] = req_tdata[CRD_W*i +: CRD_W];
   end

   tcp_cull u_cull (
      .clock (clock),
      .en    (adv),
      .v     (v),
      .cfg   (cfg_ff),
      .vis   (vis_c)
   );

   // align the cull flag with the divider outputs
   always_ff @(posedge clock) begin
      if (adv) begin
         vis_dly_ff[0] <= vis_c;
         for (int i = 1; i < VIS_DLY; i++) begin
            vis_dly_ff[i] <= vis_dly_ff[i-1];
         end
      end
   end
   assign vis = vis_dly_ff[VIS_DLY-1];

   for (genvar i = 0; i < 3; i++) begin : g_vtx
      tcp_proj u_proj (
         .clock (clock),
         .en    (adv),
         .vx    (v[3*i]),
         .vy    (v[3*i+1]),
         .vz    (v[3*i+2]),
         .cfg   (cfg_ff),
         .dx    (dx[i]),
         .dy    (dy[i])
      );
      tcp_div u_div_x (
         .clock (clock),
         .en    (adv),
         .din   (dx[i]),
         .pix   (pxs[i])
      );
      tcp_div u_div_y (
         .clock (clock),
         .en    (adv),
         .din   (dy[i]),
         .pix   (pys[i])
      );
   end

   assign rsp_tvalid = valid_ff[TOTAL_LAT-1];
   assign rsp_tuser  = vis;
   // culled triangles report zero coordinates
   assign rsp_tdata  = vis ? {pys[2], pxs[2], pys[1], pxs[1], pys[0], pxs[0]} : '0;

`include "triangle_cull_and_project_unit_assert.svh"

   `TCP_ASSERT_NOW(a_culled_zero, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)
   `TCP_ASSERT_NEXT(a_accept_enters, req_tvalid && req_tready, valid_ff[0])
   `TCP_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_tvalid)

endmodule

`default_nettype wire
